>>> hdl/tea_variant_block_decipher_defines.svh
// assertion macros shared by the decipher rtl
`ifndef TEA_VARIANT_BLOCK_DECIPHER_DEFINES_SVH
`define TEA_VARIANT_BLOCK_DECIPHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TVBD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvbd assertion failed");

// next-cycle implication, checked outside reset
`define TVBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvbd assertion failed");

`endif

>>> hdl/tvbd_pkg.sv
// types, constants and round function of the tea-variant block decipher
`timescale 1ns / 1ps
package tvbd_pkg;

   localparam int unsigned WORD_W            = 32;
   localparam int unsigned KEY_WORDS         = 4;
   localparam int unsigned ROUNDS            = 16;
   localparam int unsigned UPDATES_PER_ROUND = 4;
   localparam int unsigned STAGES            = ROUNDS * UPDATES_PER_ROUND;
   localparam int unsigned CSR_INDEX_W       = $clog2(KEY_WORDS);
   localparam logic [WORD_W-1:0] DELTA       = 32'h9E37_79B9;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [KEY_WORDS-1:0] key_type;

   // which word a pipeline stage rewrites, in round order
   typedef enum logic [1:0] {
      UPD_W3 = 2'd0,
      UPD_W2 = 2'd1,
      UPD_W1 = 2'd2,
      UPD_W0 = 2'd3
   } upd_type;

   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w2;
      word_type w3;
      logic     last;
   } block_type;

   function automatic word_type mix(input word_type x, input word_type sum,
                                    input word_type ka, input word_type kb);
      word_type a;
      word_type b;
      word_type c;
      a = x + sum;
      b = ka + (x << 4);
      c = kb + (x >> 5);
      return a ^ b ^ c;
   endfunction

   // sum used in round rnd: delta * (ROUNDS - rnd), modulo 2^32
   function automatic word_type round_sum(input int unsigned rnd);
      word_type cnt;
      cnt = WORD_W'(ROUNDS - rnd);
      return DELTA * cnt;
   endfunction

endpackage

>>> hdl/tvbd_if.sv
// stream interfaces for ciphertext requests and plaintext responses
`timescale 1ns / 1ps
interface tvbd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] cipher_w0;
   logic [31:0] cipher_w1;
   logic [31:0] cipher_w2;
   logic [31:0] cipher_w3;
   logic        last_in;

   modport source (output valid, cipher_w0, cipher_w1, cipher_w2, cipher_w3, last_in,
                   input ready);
   modport sink (input valid, cipher_w0, cipher_w1, cipher_w2, cipher_w3, last_in,
                 output ready);
endinterface

interface tvbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] plain_w0;
   logic [31:0] plain_w1;
   logic [31:0] plain_w2;
   logic [31:0] plain_w3;
   logic        last_out;

   modport source (output valid, plain_w0, plain_w1, plain_w2, plain_w3, last_out,
                   input ready);
   modport sink (input valid, plain_w0, plain_w1, plain_w2, plain_w3, last_out,
                 output ready);
endinterface

>>> hdl/tvbd_stage.sv
// one pipeline stage: a single word update of a decipher round
`timescale 1ns / 1ps
module tvbd_stage
   import tvbd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  upd_type   sel,
   input  word_type  sum,
   input  key_type   key,
   input  logic      in_valid,
   output logic      in_ready,
   input  block_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output block_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   block_type data_ff;
   block_type data_in;
   logic      load;
   word_type  x;
   word_type  ka;
   word_type  kb;
   word_type  mixed;

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // x is the word rewritten just before this one
   always_comb begin
      case (sel)
         UPD_W3: begin
            x  = in_data.w0;
            ka = key[2];
            kb = key[1];
         end
         UPD_W2: begin
            x  = in_data.w3;
            ka = key[0];
            kb = key[3];
         end
         UPD_W1: begin
            x  = in_data.w2;
            ka = key[2];
            kb = key[3];
         end
         UPD_W0: begin
            x  = in_data.w1;
            ka = key[0];
            kb = key[1];
         end
         default: begin
            x  = in_data.w0;
            ka = key[0];
            kb = key[0];
         end
      endcase
   end

   assign mixed = mix(x, sum, ka, kb);

   always_comb begin
      data_in = in_data;
      case (sel)
         UPD_W3:  data_in.w3 = in_data.w3 - mixed;
         UPD_W2:  data_in.w2 = in_data.w2 - mixed;
         UPD_W1:  data_in.w1 = in_data.w1 - mixed;
         UPD_W0:  data_in.w0 = in_data.w0 - mixed;
         default: data_in = in_data;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> hdl/tea_variant_block_decipher.sv
// Deciphers 128-bit blocks (four 32-bit words) with a 16-round TEA-style cipher under a
// 128-bit key held in four write-only key registers (csr index 0..3, reset to zero; write
// them only while no transaction is in flight). Each round is four word updates, and each
// update is one register stage, so the pipeline is 64 stages deep: a block accepted on req
// passes through every stage to rsp, and a new block is taken every cycle as long as rsp keeps
// draining. Every stage holds its own valid bit, so bubbles are squeezed out and a stalled
// rsp only stops the stages that are full; the ready path runs combinationally from
// rsp.ready back through the stages to req.ready. The last flag travels with its block.
`timescale 1ns / 1ps
`include "tea_variant_block_decipher_defines.svh"
module tea_variant_block_decipher
   import tvbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   tvbd_req_if.sink               req,
   tvbd_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   key_type   key_ff;
   logic      stg_valid [STAGES+1];
   logic      stg_ready [STAGES+1];
   block_type stg_data  [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   assign stg_valid[0]      = req.valid;
   assign req.ready         = stg_ready[0];
   assign stg_data[0].w0    = req.cipher_w0;
   assign stg_data[0].w1    = req.cipher_w1;
   assign stg_data[0].w2    = req.cipher_w2;
   assign stg_data[0].w3    = req.cipher_w3;
   assign stg_data[0].last  = req.last_in;

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      tvbd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .sel       (upd_type'(2'(g % UPDATES_PER_ROUND))),
         .sum       (round_sum(g / UPDATES_PER_ROUND)),
         .key       (key_ff),
         .in_valid  (stg_valid[g]),
         .in_ready  (stg_ready[g]),
         .in_data   (stg_data[g]),
         .out_valid (stg_valid[g+1]),
         .out_ready (stg_ready[g+1]),
         .out_data  (stg_data[g+1])
      );
   end

   assign stg_ready[STAGES] = rsp.ready;
   assign rsp.valid         = stg_valid[STAGES];
   assign rsp.plain_w0      = stg_data[STAGES].w0;
   assign rsp.plain_w1      = stg_data[STAGES].w1;
   assign rsp.plain_w2      = stg_data[STAGES].w2;
   assign rsp.plain_w3      = stg_data[STAGES].w3;
   assign rsp.last_out      = stg_data[STAGES].last;

   // an accepted transaction always lands in the first stage
   `TVBD_ASSERT_NEXT(a_accept_fills_first, clock, reset, req.valid && req.ready, stg_valid[0+1])

   // back-pressure reaches the input only when the first stage is full
   `TVBD_ASSERT_IMPL(a_ready_only_when_full, clock, reset, !req.ready, stg_valid[1])

   // a held response stays put while the sink stalls
   `TVBD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp.valid && !rsp.ready,
                     rsp.valid && $stable(rsp.plain_w0) && $stable(rsp.last_out))

endmodule
